// ===== hw/rtl/fcr_pkg.sv =====
`default_nettype none

package fcr_pkg;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_CMD,
        PH_LEN,
        PH_PAYLOAD,
        PH_SUM,
        PH_TAIL
    } phase_t;

    typedef enum logic [1:0] {
        KIND_SET  = 2'd0,
        KIND_READ = 2'd1,
        KIND_ACK  = 2'd2
    } kind_t;

    localparam logic [2:0] REG_HEADER    = 3'd0;
    localparam logic [2:0] REG_TAIL      = 3'd1;
    localparam logic [2:0] REG_MAX_LEN   = 3'd2;
    localparam logic [2:0] REG_SET_FIRST = 3'd3;
    localparam logic [2:0] REG_SET_LAST  = 3'd4;
    localparam logic [2:0] REG_READ_A    = 3'd5;
    localparam logic [2:0] REG_READ_B    = 3'd6;
    localparam logic [2:0] REG_ACK_CMD   = 3'd7;

    localparam logic [7:0] SET_LEN      = 8'd4;
    localparam int         ACK_LEN      = 6;
    localparam logic [7:0] ACK_LEN_BYTE = 8'h01;
    localparam logic [7:0] ACK_ZERO     = 8'h00;

    localparam logic [2:0] ACK_HDR_IDX  = 3'd0;
    localparam logic [2:0] ACK_CMD_IDX  = 3'd1;
    localparam logic [2:0] ACK_LEN_IDX  = 3'd2;
    localparam logic [2:0] ACK_ZERO_IDX = 3'd3;
    localparam logic [2:0] ACK_SUM_IDX  = 3'd4;
    localparam logic [2:0] ACK_TAIL_IDX = 3'd5;

    typedef struct packed {
        logic [7:0] header_byte;
        logic [7:0] tail_byte;
        logic [7:0] max_payload;
        logic [7:0] set_cmd_first;
        logic [7:0] set_cmd_last;
        logic [7:0] read_cmd_a;
        logic [7:0] read_cmd_b;
        logic [7:0] ack_cmd;
    } cfg_t;

    typedef struct packed {
        logic        is_set;
        logic        has_value;
        logic [7:0]  cmd;
        logic [31:0] value;
    } job_t;

endpackage

`default_nettype wire

// ===== hw/rtl/fcr_front.sv =====
`default_nettype none

module fcr_front
    import fcr_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire cfg_t       cfg,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,
    input  wire logic       q_full,
    output logic            push,
    output job_t            job
);

    phase_t      phase_reg, phase_next;
    logic [7:0]  cmd_reg, cmd_next;
    logic [7:0]  len_reg, len_next;
    logic [7:0]  count_reg, count_next;
    logic [7:0]  sum_reg, sum_next;
    logic [31:0] word_reg, word_next;
    logic [7:0]  rsum_reg, rsum_next;
    logic        take;
    logic        is_set;
    logic        is_read;
    logic [7:0]  count_inc;

    assign s_tready = !q_full;
    assign take     = s_tvalid && s_tready;

    assign is_set  = (cmd_reg >= cfg.set_cmd_first) && (cmd_reg <= cfg.set_cmd_last);
    assign is_read = (cmd_reg == cfg.read_cmd_a) || (cmd_reg == cfg.read_cmd_b);
    assign count_inc = count_reg + 8'd1;

    always_comb begin
        job.is_set    = is_set;
        job.has_value = (len_reg == SET_LEN);
        job.cmd       = cmd_reg;
        job.value     = word_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            cmd_reg   <= '0;
            len_reg   <= '0;
            count_reg <= '0;
            sum_reg   <= '0;
            word_reg  <= '0;
            rsum_reg  <= '0;
        end else begin
            phase_reg <= phase_next;
            cmd_reg   <= cmd_next;
            len_reg   <= len_next;
            count_reg <= count_next;
            sum_reg   <= sum_next;
            word_reg  <= word_next;
            rsum_reg  <= rsum_next;
        end
    end

    always_comb begin
        phase_next = phase_reg;
        cmd_next   = cmd_reg;
        len_next   = len_reg;
        count_next = count_reg;
        sum_next   = sum_reg;
        word_next  = word_reg;
        rsum_next  = rsum_reg;
        push       = 1'b0;
        if (take) begin
            case (phase_reg)
                PH_IDLE: begin
                    if (s_tdata == cfg.header_byte) begin
                        sum_next   = s_tdata;
                        word_next  = '0;
                        count_next = '0;
                        phase_next = PH_CMD;
                    end
                end
                PH_CMD: begin
                    cmd_next   = s_tdata;
                    sum_next   = sum_reg + s_tdata;
                    phase_next = PH_LEN;
                end
                PH_LEN: begin
                    len_next   = s_tdata;
                    sum_next   = sum_reg + s_tdata;
                    count_next = '0;
                    word_next  = '0;
                    if (s_tdata > cfg.max_payload) begin
                        phase_next = PH_IDLE;
                    end else if (s_tdata == 8'd0) begin
                        phase_next = PH_SUM;
                    end else begin
                        phase_next = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    if (count_reg < SET_LEN) begin
                        case (count_reg[1:0])
                            2'd0:    word_next[7:0]   = word_reg[7:0] | s_tdata;
                            2'd1:    word_next[15:8]  = word_reg[15:8] | s_tdata;
                            2'd2:    word_next[23:16] = word_reg[23:16] | s_tdata;
                            default: word_next[31:24] = word_reg[31:24] | s_tdata;
                        endcase
                    end
                    sum_next   = sum_reg + s_tdata;
                    count_next = count_inc;
                    if (count_inc >= len_reg) begin
                        phase_next = PH_SUM;
                    end
                end
                PH_SUM: begin
                    rsum_next  = s_tdata;
                    phase_next = PH_TAIL;
                end
                PH_TAIL: begin
                    if (s_tdata == cfg.tail_byte && sum_reg == rsum_reg) begin
                        push = is_set || is_read;
                    end
                    phase_next = PH_IDLE;
                end
                default: begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_push_in_tail: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (phase_reg == PH_TAIL) && !q_full)
        else $error("frame pushed outside the tail byte or into a full queue");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/fcr_queue.sv =====
`default_nettype none

module fcr_queue
    import fcr_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  wire job_t push_job,
    input  wire logic pop,
    output job_t      head,
    output logic      empty,
    output logic      full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign empty   = (count_reg == CNT_W'(0));
    assign full    = (count_reg == CNT_W'(DEPTH));
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + CNT_W'(1);
            2'b01:   count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count above depth");
    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !empty)
        else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/fcr_back.sv =====
`default_nettype none

module fcr_back
    import fcr_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire cfg_t        cfg,
    input  wire job_t        head,
    input  wire logic        q_empty,
    output logic             pop,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // command[7:0], set_value[39:8], tx_byte[47:40]
    output logic [1:0]       m_tuser,   // kind[1:0]
    output logic             m_tlast
);

    logic [2:0]  step_reg, step_next;
    logic        valid_reg, valid_next;
    logic [47:0] data_reg;
    logic [1:0]  user_reg;
    logic        last_reg;
    logic [2:0]  last_step;
    logic [2:0]  ack_idx;
    logic [7:0]  ack_byte;
    logic [7:0]  ack_sum;
    kind_t       kind;
    logic        load;
    logic        at_last;
    logic [31:0] value;
    logic [7:0]  tx;

    assign last_step = head.is_set ? (head.has_value ? 3'(ACK_LEN) : 3'(ACK_LEN - 1)) : 3'd0;
    assign ack_idx   = head.has_value ? step_reg - 3'd1 : step_reg;
    assign ack_sum   = cfg.header_byte + cfg.ack_cmd + ACK_LEN_BYTE + ACK_ZERO;

    always_comb begin
        case (ack_idx)
            ACK_HDR_IDX:  ack_byte = cfg.header_byte;
            ACK_CMD_IDX:  ack_byte = cfg.ack_cmd;
            ACK_LEN_IDX:  ack_byte = ACK_LEN_BYTE;
            ACK_ZERO_IDX: ack_byte = ACK_ZERO;
            ACK_SUM_IDX:  ack_byte = ack_sum;
            ACK_TAIL_IDX: ack_byte = cfg.tail_byte;
            default:      ack_byte = ACK_ZERO;
        endcase
    end

    always_comb begin
        if (!head.is_set) begin
            kind  = KIND_READ;
            value = '0;
            tx    = '0;
        end else if (head.has_value && step_reg == 3'd0) begin
            kind  = KIND_SET;
            value = head.value;
            tx    = '0;
        end else begin
            kind  = KIND_ACK;
            value = '0;
            tx    = ack_byte;
        end
    end

    assign load    = !q_empty && (!valid_reg || m_tready);
    assign at_last = (step_reg == last_step);
    assign pop     = load && at_last;

    always_comb begin
        step_next  = step_reg;
        valid_next = valid_reg;
        if (load) begin
            step_next  = at_last ? 3'd0 : step_reg + 3'd1;
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg  <= '0;
            valid_reg <= 1'b0;
        end else begin
            step_reg  <= step_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= {tx, value, head.cmd};
            user_reg <= kind;
            last_reg <= at_last;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;
    assign m_tlast  = last_reg;

`ifndef ASSERT_OFF
    a_step_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        step_reg <= 3'(ACK_LEN))
        else $error("result step out of range");
    a_job_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_reg != 3'd0) |-> !q_empty)
        else $error("job left the queue before its last result");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/framed_command_receiver_unit.sv =====
// An accepted frame's job is queued, then its first result is registered for output.
// Throughput: one byte per cycle in unless the job queue is full; one result per
// cycle out while m_tready is high, up to 7 per frame.
// The job queue between parser and result sequencer decouples the two sides.
// s_tready drops only while the job queue is full.
// Reset (aresetn, synchronous, active low) idles the parser, empties the queue
// and restores all configuration registers to their defaults.
`default_nettype none

module framed_command_receiver_unit
    import fcr_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // rx_data[7:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // command[7:0], set_value[39:8], tx_byte[47:40]
    output logic [1:0]       m_tuser,   // kind[1:0]
    output logic             m_tlast,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    cfg_t       cfg_reg;
    logic       cfg_wr;
    logic [2:0] reg_idx;
    logic [7:0] rd_byte;
    logic       q_push;
    logic       q_pop;
    logic       q_empty;
    logic       q_full;
    job_t       push_job;
    job_t       head_job;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.header_byte   <= 8'hAA;
            cfg_reg.tail_byte     <= 8'h55;
            cfg_reg.max_payload   <= 8'd58;
            cfg_reg.set_cmd_first <= 8'd1;
            cfg_reg.set_cmd_last  <= 8'd6;
            cfg_reg.read_cmd_a    <= 8'd16;
            cfg_reg.read_cmd_b    <= 8'd17;
            cfg_reg.ack_cmd       <= 8'd128;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_HEADER:    cfg_reg.header_byte   <= pwdata[7:0];
                REG_TAIL:      cfg_reg.tail_byte     <= pwdata[7:0];
                REG_MAX_LEN:   cfg_reg.max_payload   <= pwdata[7:0];
                REG_SET_FIRST: cfg_reg.set_cmd_first <= pwdata[7:0];
                REG_SET_LAST:  cfg_reg.set_cmd_last  <= pwdata[7:0];
                REG_READ_A:    cfg_reg.read_cmd_a    <= pwdata[7:0];
                REG_READ_B:    cfg_reg.read_cmd_b    <= pwdata[7:0];
                REG_ACK_CMD:   cfg_reg.ack_cmd       <= pwdata[7:0];
                default:       cfg_reg               <= cfg_reg;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_HEADER:    rd_byte = cfg_reg.header_byte;
            REG_TAIL:      rd_byte = cfg_reg.tail_byte;
            REG_MAX_LEN:   rd_byte = cfg_reg.max_payload;
            REG_SET_FIRST: rd_byte = cfg_reg.set_cmd_first;
            REG_SET_LAST:  rd_byte = cfg_reg.set_cmd_last;
            REG_READ_A:    rd_byte = cfg_reg.read_cmd_a;
            REG_READ_B:    rd_byte = cfg_reg.read_cmd_b;
            REG_ACK_CMD:   rd_byte = cfg_reg.ack_cmd;
            default:       rd_byte = '0;
        endcase
    end

    assign prdata = {24'd0, rd_byte};

    fcr_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .push     (q_push),
        .job      (push_job)
    );

    fcr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (push_job),
        .pop      (q_pop),
        .head     (head_job),
        .empty    (q_empty),
        .full     (q_full)
    );

    fcr_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .head     (head_job),
        .q_empty  (q_empty),
        .pop      (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

// ===== tb/framed_command_receiver_unit_test.sv =====
module framed_command_receiver_unit_test;
    import fcr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_LIMIT = 20000;
    localparam int HOLD_CYCLES = 200;
    localparam int PHASE_BYTES = 48;
    localparam int NUM_PHASES  = 5;

    typedef enum logic [1:0] {
        ROW_PREDICT,
        ROW_NONE,
        ROW_READ
    } row_chk_t;

    typedef struct packed {
        logic [7:0] data;
        row_chk_t   chk;
        logic [7:0] cmd;
    } dir_row_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  cmd;
        logic [31:0] value;
        logic [7:0]  tx;
        logic        last;
    } reply_t;

    // reset config: header 0xAA, tail 0x55, max 58, set 1..6, read 16/17
    localparam dir_row_t DIRECTED [0:26] = '{
        // set 1, len 4, payload with 0x00 and 0xFF -> value + ACK
        '{8'hAA, ROW_PREDICT, 8'h00}, '{8'h01, ROW_PREDICT, 8'h00},
        '{8'h04, ROW_PREDICT, 8'h00}, '{8'h00, ROW_PREDICT, 8'h00},
        '{8'hFF, ROW_PREDICT, 8'h00}, '{8'h12, ROW_PREDICT, 8'h00},
        '{8'h80, ROW_PREDICT, 8'h00}, '{8'h40, ROW_PREDICT, 8'h00},
        '{8'h55, ROW_PREDICT, 8'h00},
        // read A, zero length
        '{8'hAA, ROW_NONE, 8'h00}, '{8'h10, ROW_NONE, 8'h00},
        '{8'h00, ROW_NONE, 8'h00}, '{8'hBA, ROW_NONE, 8'h00},
        '{8'h55, ROW_READ, 8'h10},
        // read B, bad checksum
        '{8'hAA, ROW_NONE, 8'h00}, '{8'h11, ROW_NONE, 8'h00},
        '{8'h00, ROW_NONE, 8'h00}, '{8'h00, ROW_NONE, 8'h00},
        '{8'h55, ROW_NONE, 8'h00},
        // read A, wrong tail
        '{8'hAA, ROW_NONE, 8'h00}, '{8'h10, ROW_NONE, 8'h00},
        '{8'h00, ROW_NONE, 8'h00}, '{8'hBA, ROW_NONE, 8'h00},
        '{8'h54, ROW_NONE, 8'h00},
        // length above max, dropped
        '{8'hAA, ROW_NONE, 8'h00}, '{8'h02, ROW_NONE, 8'h00},
        '{8'h3B, ROW_NONE, 8'h00}
    };

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // parser copy
    cfg_t        cfg;
    phase_t      ph;
    logic [7:0]  frm_cmd;
    logic [7:0]  frm_len;
    logic [7:0]  pay_cnt;
    logic [7:0]  sum_acc;
    logic [31:0] pay_word;
    logic [7:0]  sum_rx;

    reply_t      new_replies[$];
    reply_t      pending_replies[$];
    reply_t      want;

    int          errors;
    int          cycle_cnt;
    int          burst_left;
    int          bytes_sent;
    bit          hold_req;

    framed_command_receiver_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 aclk = ~aclk;

    task automatic report(input string msg);
        errors++;
        $display("ERROR @%0t: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] exp_val);
        if (got !== exp_val) begin
            report($sformatf("%s got %h want %h", name, got, exp_val));
        end
    endtask

    function automatic void add_reply(input kind_t kind, input logic [31:0] value,
                                      input logic [7:0] tx, input logic last);
        reply_t r;
        r.kind  = kind;
        r.cmd   = frm_cmd;
        r.value = value;
        r.tx    = tx;
        r.last  = last;
        new_replies.push_back(r);
    endfunction

    function automatic void accept_frame();
        logic [7:0] ack_bytes [ACK_LEN];
        if (frm_cmd >= cfg.set_cmd_first && frm_cmd <= cfg.set_cmd_last) begin
            if (frm_len == SET_LEN) begin
                add_reply(KIND_SET, pay_word, 8'd0, 1'b0);
            end
            ack_bytes[0] = cfg.header_byte;
            ack_bytes[1] = cfg.ack_cmd;
            ack_bytes[2] = ACK_LEN_BYTE;
            ack_bytes[3] = ACK_ZERO;
            ack_bytes[4] = 8'(cfg.header_byte + cfg.ack_cmd + ACK_LEN_BYTE + ACK_ZERO);
            ack_bytes[5] = cfg.tail_byte;
            for (int i = 0; i < ACK_LEN; i++) begin
                add_reply(KIND_ACK, 32'd0, ack_bytes[i], i == ACK_LEN - 1);
            end
        end else if (frm_cmd == cfg.read_cmd_a || frm_cmd == cfg.read_cmd_b) begin
            add_reply(KIND_READ, 32'd0, 8'd0, 1'b1);
        end
    endfunction

    function automatic void parse_byte(input logic [7:0] b);
        case (ph)
            PH_IDLE: begin
                if (b == cfg.header_byte) begin
                    sum_acc  = b;
                    pay_word = '0;
                    pay_cnt  = '0;
                    ph       = PH_CMD;
                end
            end
            PH_CMD: begin
                frm_cmd = b;
                sum_acc = 8'(sum_acc + b);
                ph      = PH_LEN;
            end
            PH_LEN: begin
                frm_len  = b;
                sum_acc  = 8'(sum_acc + b);
                pay_cnt  = '0;
                pay_word = '0;
                if (b > cfg.max_payload) begin
                    ph = PH_IDLE;
                end else if (b == 8'd0) begin
                    ph = PH_SUM;
                end else begin
                    ph = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                // only the first four payload bytes form the word
                if (pay_cnt < 8'd4) begin
                    pay_word = pay_word | ({24'd0, b} << (8 * pay_cnt));
                end
                sum_acc = 8'(sum_acc + b);
                pay_cnt = 8'(pay_cnt + 8'd1);
                if (pay_cnt >= frm_len) begin
                    ph = PH_SUM;
                end
            end
            PH_SUM: begin
                sum_rx = b;
                ph     = PH_TAIL;
            end
            PH_TAIL: begin
                if (b == cfg.tail_byte && sum_acc == sum_rx) begin
                    accept_frame();
                end
                ph = PH_IDLE;
            end
            default: begin
                ph = PH_IDLE;
            end
        endcase
    endfunction

    // entered and left at a falling edge
    task automatic push_byte(input logic [7:0] b, input row_chk_t chk,
                             input logic [7:0] exp_cmd);
        int gap;
        reply_t r;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 6);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
            burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 12);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        bytes_sent++;
        new_replies.delete();
        parse_byte(b);
        case (chk)
            ROW_PREDICT: begin
                foreach (new_replies[i]) pending_replies.push_back(new_replies[i]);
            end
            ROW_READ: begin
                r.kind  = KIND_READ;
                r.cmd   = exp_cmd;
                r.value = 32'd0;
                r.tx    = 8'd0;
                r.last  = 1'b1;
                pending_replies.push_back(r);
            end
            default: begin
            end
        endcase
        @(negedge aclk);
    endtask

    task automatic apb_write(input logic [2:0] idx, input logic [7:0] val);
        logic [31:0] junk;
        junk = $urandom;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {junk[31:8], val};
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        case (idx)
            REG_HEADER:    cfg.header_byte   = val;
            REG_TAIL:      cfg.tail_byte     = val;
            REG_MAX_LEN:   cfg.max_payload   = val;
            REG_SET_FIRST: cfg.set_cmd_first = val;
            REG_SET_LAST:  cfg.set_cmd_last  = val;
            REG_READ_A:    cfg.read_cmd_a    = val;
            REG_READ_B:    cfg.read_cmd_b    = val;
            REG_ACK_CMD:   cfg.ack_cmd       = val;
            default: begin
            end
        endcase
        @(negedge aclk);
    endtask

    task automatic write_cfg(input cfg_t c);
        apb_write(REG_HEADER,    c.header_byte);
        apb_write(REG_TAIL,      c.tail_byte);
        apb_write(REG_MAX_LEN,   c.max_payload);
        apb_write(REG_SET_FIRST, c.set_cmd_first);
        apb_write(REG_SET_LAST,  c.set_cmd_last);
        apb_write(REG_READ_A,    c.read_cmd_a);
        apb_write(REG_READ_B,    c.read_cmd_b);
        apb_write(REG_ACK_CMD,   c.ack_cmd);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
    endtask

    function automatic cfg_t phase_cfg(input int p);
        cfg_t c;
        case (p)
            0: c = '{8'hAA, 8'h55, 8'd58, 8'd1, 8'd6, 8'd16, 8'd17, 8'd128};
            1: c = '{8'h00, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00};
            2: c = '{8'hFF, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'hFF};
            // header equals tail, read codes overlap the set range
            3: c = '{8'h7E, 8'h7E, 8'd8, 8'd10, 8'd20, 8'd16, 8'd20, 8'h7F};
            default: begin
                c = cfg_t'({$urandom, $urandom});
            end
        endcase
        return c;
    endfunction

    // wait for every pending result, then let the block go quiet
    task automatic settle();
        int waited;
        waited = 0;
        s_tvalid   <= 1'b0;
        burst_left = 0;
        while (pending_replies.size() != 0 && waited < DRAIN_LIMIT) begin
            @(negedge aclk);
            waited++;
        end
        if (pending_replies.size() != 0) begin
            report($sformatf("%0d results never arrived", pending_replies.size()));
            pending_replies.delete();
        end
        repeat (8) @(negedge aclk);
    endtask

    task automatic send_frame();
        int r;
        logic [7:0] cmd;
        logic [7:0] len;
        logic [7:0] sum;
        logic [7:0] b;
        if ($urandom_range(0, 6) == 0) begin
            repeat ($urandom_range(1, 3)) push_byte(8'($urandom), ROW_PREDICT, 8'd0);
        end
        case ($urandom_range(0, 9))
            0, 1, 2, 3: cmd = 8'($urandom_range(cfg.set_cmd_first, cfg.set_cmd_last));
            4, 5:       cmd = cfg.read_cmd_a;
            6:          cmd = cfg.read_cmd_b;
            default:    cmd = 8'($urandom);
        endcase
        r = $urandom_range(0, 99);
        if (r < 55) begin
            len = SET_LEN;
        end else if (r < 85) begin
            len = 8'($urandom_range(0, 6));
        end else if (r < 93) begin
            len = 8'($urandom_range(0, cfg.max_payload));
        end else if (cfg.max_payload == 8'hFF) begin
            len = 8'($urandom);
        end else begin
            len = 8'($urandom_range(cfg.max_payload + 1, 255));
        end
        sum = 8'(cfg.header_byte + cmd + len);
        push_byte(cfg.header_byte, ROW_PREDICT, 8'd0);
        push_byte(cmd, ROW_PREDICT, 8'd0);
        push_byte(len, ROW_PREDICT, 8'd0);
        if (len > cfg.max_payload) begin
            return;
        end
        for (int i = 0; i < len; i++) begin
            b   = 8'($urandom);
            sum = 8'(sum + b);
            push_byte(b, ROW_PREDICT, 8'd0);
        end
        if ($urandom_range(0, 99) < 12) begin
            sum = 8'(sum + $urandom_range(1, 255));
        end
        push_byte(sum, ROW_PREDICT, 8'd0);
        b = cfg.tail_byte;
        if ($urandom_range(0, 9) == 0) begin
            b = b ^ 8'($urandom_range(1, 255));
        end
        push_byte(b, ROW_PREDICT, 8'd0);
    endtask

    // result checking
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_replies.size() == 0) begin
                report($sformatf("unexpected result transfer kind %0d cmd %h",
                                 m_tuser, m_tdata[7:0]));
            end else begin
                want = pending_replies.pop_front();
                check_field("kind",      32'(m_tuser),        32'(want.kind));
                check_field("command",   32'(m_tdata[7:0]),   32'(want.cmd));
                check_field("set_value", m_tdata[39:8],       want.value);
                check_field("tx_byte",   32'(m_tdata[47:40]), 32'(want.tx));
                check_field("last",      32'(m_tlast),        32'(want.last));
            end
        end
    end

    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("framed_command_receiver_unit_test: FAIL");
            $finish;
        end
    end

    // receiver stall pattern, with one long hold-off on request
    initial begin
        int mode;
        int cnt;
        mode = 0;
        cnt  = 0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_req = 1'b0;
            end else begin
                if (cnt % 64 == 0) begin
                    mode = $urandom_range(0, 3);
                end
                cnt++;
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    2:       m_tready <= (cnt % 4 == 0);
                    default: m_tready <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    initial begin
        aclk       = 1'b0;
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = 8'd0;
        m_tready   = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        errors     = 0;
        cycle_cnt  = 0;
        burst_left = 0;
        bytes_sent = 0;
        hold_req   = 1'b0;
        cfg        = phase_cfg(0);
        ph         = PH_IDLE;
        frm_cmd    = '0;
        frm_len    = '0;
        pay_cnt    = '0;
        sum_acc    = '0;
        pay_word   = '0;
        sum_rx     = '0;

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (DIRECTED[i]) begin
            push_byte(DIRECTED[i].data, DIRECTED[i].chk, DIRECTED[i].cmd);
        end
        settle();

        for (int p = 0; p < NUM_PHASES; p++) begin
            write_cfg(phase_cfg(p));
            if (p == 0) begin
                hold_req = 1'b1;
            end
            bytes_sent = 0;
            while (bytes_sent < PHASE_BYTES) begin
                send_frame();
            end
            settle();
        end

        if (errors == 0) begin
            $display("framed_command_receiver_unit_test: PASS");
        end else begin
            $display("framed_command_receiver_unit_test: FAIL");
        end
        $finish;
    end

endmodule
